@@ design/nlcm_pkg.sv @@
// Shared constants, types and helpers for the NFA lambda-closure and move block.
`default_nettype none

package nlcm_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 16;

    localparam int STATE_W   = 6;
    localparam int SYM_W     = 4;
    localparam int KIND_W    = 2;
    localparam int SET_W     = 64;
    localparam int ROW_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int ROW_W     = $clog2(ROW_DEPTH);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [SYM_W-1:0] SYM_LAMBDA = '0;

    localparam logic [KIND_W-1:0] KIND_ADD_EDGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSURE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE     = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_CLO_PICK,
        S_CLO_OR,
        S_MOV_PICK,
        S_MOV_OR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               found;
        logic [STATE_W-1:0] idx;
        logic [SET_W-1:0]   mask;
    } t_lowbit;

    // Row address of (state, symbol): state * NUM_SYMBOLS + symbol.
    function automatic logic [ROW_W-1:0] row_addr(input logic [STATE_W-1:0] st,
                                                  input logic [SYM_W-1:0] sym);
        logic [ROW_W-1:0] base;
        base = ROW_W'(st) * ROW_W'(NUM_SYMBOLS);
        return base + ROW_W'(sym);
    endfunction

endpackage

`default_nettype wire

@@ design/nfa_lambda_closure_and_move.sv @@
// Top level: NFA transition store with lambda-closure and symbol-move queries.
// Add edge: accept, row read, row write back.
// Closure: a pick and an OR step per closure member, then one beat per member.
// Move adds a pick and an OR step per closure member over the closure before emit.
// Throughput: one item at a time; the single row-store read port sets the pace.
// Reset: a clearing pass writes all 1024 rows to zero; input is not ready until it ends.
`default_nettype none

module nfa_lambda_closure_and_move
    import nlcm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [5:0] source_state, [11:6] target_state, [15:12] symbol
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind
    input  wire logic [KIND_W-1:0]      i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [5:0] member_state, [7:6] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // last_member
    output logic                        o_m_axis_tlast,
    // [0] set_empty
    output logic                        o_m_axis_tuser
);

    // Input beat fields.
    logic [STATE_W-1:0] w_in_src;
    logic [STATE_W-1:0] w_in_dst;
    logic [SYM_W-1:0]   w_in_sym;
    logic [KIND_W-1:0]  w_in_kind;
    logic               w_src_ok;
    logic               w_dst_ok;
    logic               w_sym_ok;
    logic               w_accept;
    logic               w_out_free;

    assign w_in_src  = i_s_axis_tdata[STATE_W-1:0];
    assign w_in_dst  = i_s_axis_tdata[2*STATE_W-1:STATE_W];
    assign w_in_sym  = i_s_axis_tdata[2*STATE_W+SYM_W-1:2*STATE_W];
    assign w_in_kind = i_s_axis_tuser;

    // Out-of-range states and symbols are dropped on add and give empty sets on query.
    assign w_src_ok = {1'b0, w_in_src} < (STATE_W+1)'(NUM_STATES);
    assign w_dst_ok = {1'b0, w_in_dst} < (STATE_W+1)'(NUM_STATES);
    assign w_sym_ok = {1'b0, w_in_sym} < (SYM_W+1)'(NUM_SYMBOLS);

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic               r_is_move, n_is_move;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [STATE_W-1:0] r_dst, n_dst;
    logic [ROW_W-1:0]   r_addr, n_addr;
    logic [SET_W-1:0]   r_set, n_set;    // closure, then result set being emitted
    logic [SET_W-1:0]   r_mark, n_mark;  // expanded members, then members left to move
    logic [SET_W-1:0]   r_acc, n_acc;    // move target accumulator

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [STATE_W-1:0] r_out_member, n_out_member;
    logic               r_out_last, n_out_last;
    logic               r_out_empty, n_out_empty;

    // Row store port.
    logic               w_we;
    logic [ROW_W-1:0]   w_waddr;
    logic [SET_W-1:0]   w_wdata;
    logic               w_re;
    logic [ROW_W-1:0]   w_raddr;
    logic [SET_W-1:0]   w_rdata;

    // Shared lowest-bit search.
    logic [SET_W-1:0]   w_scan;
    t_lowbit            w_low;
    logic [SET_W-1:0]   w_rem;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_rem           = r_set & ~w_low.mask;

    nlcm_row_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Pick what the search unit looks at in each step.
    always_comb begin
        case (r_state)
            S_CLO_PICK: w_scan = r_set & ~r_mark;
            S_MOV_PICK: w_scan = r_mark;
            default:    w_scan = r_set;
        endcase
    end

    nlcm_lowbit u_lowbit (
        .i_vec (w_scan),
        .o_low (w_low)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == ROW_W'(ROW_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_in_kind)
                        KIND_ADD_EDGE: begin
                            if (w_src_ok && w_dst_ok && w_sym_ok) begin
                                n_state = S_ADD_RD;
                            end
                        end
                        KIND_CLOSURE: n_state = w_src_ok ? S_CLO_PICK : S_EMIT;
                        KIND_MOVE:    n_state = (w_src_ok && w_sym_ok) ? S_CLO_PICK : S_EMIT;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: n_state = S_IDLE;
            S_CLO_PICK: begin
                if (w_low.found) begin
                    n_state = S_CLO_OR;
                end else begin
                    n_state = r_is_move ? S_MOV_PICK : S_EMIT;
                end
            end
            S_CLO_OR: n_state = S_CLO_PICK;
            S_MOV_PICK: n_state = w_low.found ? S_MOV_OR : S_EMIT;
            S_MOV_OR: n_state = S_MOV_PICK;
            S_EMIT: begin
                if (w_out_free && (!w_low.found || (w_rem == '0))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath, store port and output register.
    always_comb begin
        n_clr_cnt    = r_clr_cnt;
        n_is_move    = r_is_move;
        n_sym        = r_sym;
        n_dst        = r_dst;
        n_addr       = r_addr;
        n_set        = r_set;
        n_mark       = r_mark;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_member = r_out_member;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = w_rdata | (SET_W'(1) << r_dst);
        w_re         = 1'b0;
        w_raddr      = r_addr;
        case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_cnt;
                w_wdata   = '0;
                n_clr_cnt = r_clr_cnt + ROW_W'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_is_move = (w_in_kind == KIND_MOVE);
                    n_sym     = w_in_sym;
                    n_dst     = w_in_dst;
                    n_addr    = row_addr(w_in_src, w_in_sym);
                    n_mark    = '0;
                    n_acc     = '0;
                    // Seed the closure with the source; a bad query seeds nothing.
                    if (w_src_ok && ((w_in_kind == KIND_CLOSURE) || w_sym_ok)) begin
                        n_set = SET_W'(1) << w_in_src;
                    end else begin
                        n_set = '0;
                    end
                end
            end
            S_ADD_RD: begin
                w_re = 1'b1;
            end
            S_ADD_WR: begin
                // Merge the target bit into the row just read.
                w_we = 1'b1;
            end
            S_CLO_PICK: begin
                if (w_low.found) begin
                    n_mark  = r_mark | w_low.mask;
                    w_re    = 1'b1;
                    w_raddr = row_addr(w_low.idx, SYM_LAMBDA);
                end else begin
                    n_mark = r_set;
                    n_acc  = '0;
                end
            end
            S_CLO_OR: begin
                n_set = r_set | w_rdata;
            end
            S_MOV_PICK: begin
                if (w_low.found) begin
                    n_mark  = r_mark & ~w_low.mask;
                    w_re    = 1'b1;
                    w_raddr = row_addr(w_low.idx, r_sym);
                end else begin
                    n_set = r_acc;
                end
            end
            S_MOV_OR: begin
                n_acc = r_acc | w_rdata;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_low.found) begin
                        n_out_member = w_low.idx;
                        n_out_last   = (w_rem == '0);
                        n_out_empty  = 1'b0;
                        n_set        = w_rem;
                    end else begin
                        n_out_member = '0;
                        n_out_last   = 1'b1;
                        n_out_empty  = 1'b1;
                    end
                end
            end
            default: begin
                n_clr_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_move    <= n_is_move;
        r_sym        <= n_sym;
        r_dst        <= n_dst;
        r_addr       <= n_addr;
        r_set        <= n_set;
        r_mark       <= n_mark;
        r_acc        <= n_acc;
        r_out_member <= n_out_member;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - STATE_W)'(0), r_out_member};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_empty;

endmodule

`default_nettype wire

@@ design/nlcm_row_ram.sv @@
// Transition row store: one write port, one registered read port.
`default_nettype none

module nlcm_row_ram
    import nlcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [ROW_W-1:0] i_waddr,
    input  wire logic [SET_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [ROW_W-1:0] i_raddr,
    output logic      [SET_W-1:0] o_rdata
);

    logic [SET_W-1:0] r_mem [ROW_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/nlcm_lowbit.sv @@
// Lowest-set-bit finder shared by closure, move and emit steps.
`default_nettype none

module nlcm_lowbit
    import nlcm_pkg::*;
(
    input  wire logic [SET_W-1:0] i_vec,
    output t_lowbit               o_low
);

    logic [SET_W-1:0]   w_mask;
    logic [STATE_W-1:0] w_idx;

    // Isolate the lowest one with two's complement.
    assign w_mask = i_vec & (~i_vec + SET_W'(1));

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < SET_W; i++) begin
            if (w_mask[i]) begin
                w_idx = w_idx | STATE_W'(i);
            end
        end
    end

    assign o_low.found = |i_vec;
    assign o_low.idx   = w_idx;
    assign o_low.mask  = w_mask;

endmodule

`default_nettype wire

@@ design/nlcm_checker.sv @@
// Port-level checks for the NFA lambda-closure and move block, bound to the top level.
`default_nettype none

module nlcm_checker
    import nlcm_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input wire logic [KIND_W-1:0]      i_s_axis_tuser,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tlast,
    input wire logic                   o_m_axis_tuser
);

    // Reset empties the output and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("output valid or input ready right after reset");

    // A stalled beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("stalled output beat changed");

    // An empty-set beat is the last beat of its query and carries member zero.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("empty-set beat not last or member not zero");

    // No new item while a query still has members to send.
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input ready in the middle of a result run");

    // Members of one query come out in strictly ascending order.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            !o_m_axis_tvalid ||
            (o_m_axis_tdata[STATE_W-1:0] > $past(o_m_axis_tdata[STATE_W-1:0])))
        else $error("result members out of order");

endmodule

bind nfa_lambda_closure_and_move nlcm_checker u_nlcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_nfa_lambda_closure_and_move.sv @@
// Testbench for the NFA lambda-closure and move block: predicts member beats and checks them.
module tb_nfa_lambda_closure_and_move;
    import nlcm_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int CALM_TAIL    = 30;   // no idling while this few commands remain
    localparam int DRAIN_CYCLES = 400;  // longest closure plus move walk, with margin
    localparam int LONG_HOLD    = 400;  // one long receiver hold-off
    localparam int HOLD_AFTER   = 30;   // start that hold-off after this many beats

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [SYM_W-1:0]   sym;
        bit                 drain_first;  // pause marker: wait for every result first
    } nfa_cmd_t;

    typedef struct {
        logic [STATE_W-1:0] member_state;
        logic               last_member;
        logic               set_empty;
    } member_beat_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Slave side of the block, driven here.
    logic                  in_valid = 1'b0;
    logic [IN_TDATA_W-1:0] in_data  = '0;
    logic [KIND_W-1:0]     in_kind  = '0;
    logic                  o_s_axis_tready;

    // Master side of the block, sampled here.
    logic                   out_ready = 1'b0;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   o_m_axis_tuser;

    nfa_lambda_closure_and_move dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_data),      // [5:0] source, [11:6] target, [15:12] symbol
        .i_s_axis_tuser  (in_kind),      // [1:0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [5:0] member_state, [7:6] zero
        .o_m_axis_tlast  (o_m_axis_tlast),  // last_member
        .o_m_axis_tuser  (o_m_axis_tuser)   // [0] set_empty
    );

    // Own copy of the transition store: one to-state set per source and symbol.
    logic [SET_W-1:0] nfa_rows [NUM_STATES][NUM_SYMBOLS];

    nfa_cmd_t     cmd_backlog[$];
    member_beat_t pending_members[$];
    nfa_cmd_t     in_cmd;
    member_beat_t beat_want;

    int mismatch_count = 0;
    int beats_seen     = 0;
    int cycle_count    = 0;

    // --------------------------------------------------------------------
    // Prediction
    // --------------------------------------------------------------------

    // Grow the set by rounds over lambda rows until a round adds nothing.
    function automatic logic [SET_W-1:0] lambda_closure(input logic [STATE_W-1:0] st);
        logic [SET_W-1:0] reach;
        logic [SET_W-1:0] grown;
        int i;
        if (st >= NUM_STATES)
            return '0;
        grown = '0;
        grown[st] = 1'b1;
        do begin
            reach = grown;
            for (i = 0; i < NUM_STATES; i++)
                if (reach[i])
                    grown |= nfa_rows[i][SYM_LAMBDA];
        end while (grown != reach);
        return reach;
    endfunction

    // One symbol step from the closure of st; no closure after the step.
    function automatic logic [SET_W-1:0] symbol_move(input logic [STATE_W-1:0] st,
                                                     input logic [SYM_W-1:0] sym);
        logic [SET_W-1:0] from;
        logic [SET_W-1:0] to;
        int i;
        if (sym >= NUM_SYMBOLS)
            return '0;
        from = lambda_closure(st);
        to   = '0;
        for (i = 0; i < NUM_STATES; i++)
            if (from[i])
                to |= nfa_rows[i][sym];
        return to;
    endfunction

    // Queue the member beats of a set in ascending order; empty set gives one flagged beat.
    function automatic void expect_members(input logic [SET_W-1:0] set);
        member_beat_t b;
        int i;
        if (set == '0) begin
            b = '{member_state: '0, last_member: 1'b1, set_empty: 1'b1};
            pending_members = {pending_members, b};
            return;
        end
        for (i = 0; i < SET_W; i++) begin
            if (set[i]) begin
                b = '{member_state: STATE_W'(i), last_member: 1'b0, set_empty: 1'b0};
                pending_members = {pending_members, b};
            end
        end
        pending_members[pending_members.size()-1].last_member = 1'b1;
    endfunction

    // Apply one accepted command to the store copy and queue what it yields.
    function automatic void apply_nfa_cmd(input nfa_cmd_t c);
        case (c.kind)
            KIND_ADD_EDGE: begin
                if (c.src < NUM_STATES && c.dst < NUM_STATES && c.sym < NUM_SYMBOLS)
                    nfa_rows[c.src][c.sym][c.dst] = 1'b1;
            end
            KIND_CLOSURE: expect_members(lambda_closure(c.src));
            KIND_MOVE:    expect_members(symbol_move(c.src, c.sym));
            default: ;
        endcase
    endfunction

    // --------------------------------------------------------------------
    // Stimulus helpers
    // --------------------------------------------------------------------

    function automatic void queue_cmd(input logic [KIND_W-1:0] kind,
                                      input logic [STATE_W-1:0] src,
                                      input logic [STATE_W-1:0] dst,
                                      input logic [SYM_W-1:0] sym);
        nfa_cmd_t c;
        c = '{kind: kind, src: src, dst: dst, sym: sym, drain_first: 1'b0};
        cmd_backlog = {cmd_backlog, c};
    endfunction

    function automatic void queue_drain_pause();
        nfa_cmd_t c;
        c = '{kind: KIND_UNUSED, src: '0, dst: '0, sym: '0, drain_first: 1'b1};
        cmd_backlog = {cmd_backlog, c};
    endfunction

    function automatic logic [STATE_W-1:0] any_state();
        return STATE_W'($urandom_range(0, NUM_STATES - 1));
    endfunction

    function automatic logic [SYM_W-1:0] any_symbol();
        return SYM_W'($urandom_range(0, NUM_SYMBOLS - 1));
    endfunction

    // --------------------------------------------------------------------
    // Clock and timeout
    // --------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // Driver: present backlog commands, one beat per handshake
    // --------------------------------------------------------------------

    int send_gap   = 0;
    bit send_calm  = 1'b0;
    bit send_quiet = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Predict at acceptance so the store copy follows the block's order.
            if (in_valid && o_s_axis_tready)
                apply_nfa_cmd(in_cmd);

            send_calm = (cmd_backlog.size() <= CALM_TAIL);
            if ($urandom_range(0, 19) == 0)
                send_quiet = $urandom_range(0, 1);

            // Only touch the slave side once the current beat is gone.
            if (!in_valid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0 && cmd_backlog[0].drain_first) begin
                    // Hold off until every queued result has come out.
                    if (pending_members.size() == 0)
                        void'(cmd_backlog.pop_front());
                    in_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    in_cmd   <= cmd_backlog[0];
                    in_data  <= {cmd_backlog[0].sym, cmd_backlog[0].dst, cmd_backlog[0].src};
                    in_kind  <= cmd_backlog[0].kind;
                    in_valid <= 1'b1;
                    void'(cmd_backlog.pop_front());
                    // Idle after this beat now and then.
                    if (!send_calm && !send_quiet && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // Monitor: take result beats and compare with the oldest expectation
    // --------------------------------------------------------------------

    int  recv_hold      = 0;
    int  recv_stall     = 0;
    bit  recv_quiet     = 1'b0;
    bit  long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && out_ready) begin
                beats_seen++;
                if (pending_members.size() == 0) begin
                    $error("unexpected result beat: member_state %0d last %0d empty %0d",
                           o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                    mismatch_count++;
                end else begin
                    beat_want = pending_members.pop_front();
                    if (o_m_axis_tdata !== OUT_TDATA_W'(beat_want.member_state)) begin
                        $error("member_state: expected %0d, got %0d",
                               beat_want.member_state, o_m_axis_tdata);
                        mismatch_count++;
                    end
                    if (o_m_axis_tlast !== beat_want.last_member) begin
                        $error("last_member: expected %0d, got %0d",
                               beat_want.last_member, o_m_axis_tlast);
                        mismatch_count++;
                    end
                    if (o_m_axis_tuser !== beat_want.set_empty) begin
                        $error("set_empty: expected %0d, got %0d",
                               beat_want.set_empty, o_m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end

            if ($urandom_range(0, 31) == 0)
                recv_quiet = $urandom_range(0, 1);

            // Once, hold off long enough that the block backs up and stalls its input.
            if (!long_hold_done && beats_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                recv_hold      = LONG_HOLD;
            end

            if (recv_hold > 0) begin
                recv_hold--;
                out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!send_calm && !recv_quiet && $urandom_range(0, 5) == 0)
                    recv_stall = $urandom_range(1, 5);
            end
        end
    end

    // --------------------------------------------------------------------
    // Stimulus and end of run
    // --------------------------------------------------------------------

    logic [STATE_W-1:0] grp [6];
    logic [STATE_W-1:0] fan_order [NUM_STATES];
    logic [STATE_W-1:0] swap_tmp;
    logic [SYM_W-1:0]   letter_a, letter_b, pick_sym;
    logic [STATE_W-1:0] fan_src;
    int                 c, j, n, r, k;

    initial begin
        for (j = 0; j < NUM_STATES; j++)
            for (k = 0; k < NUM_SYMBOLS; k++)
                nfa_rows[j][k] = '0;

        // Directed: empty store, extremes, repeated edge, ignored kind.
        queue_cmd(KIND_MOVE, 6'd63, 6'd63, 4'd15);          // nothing stored: empty set
        queue_cmd(KIND_CLOSURE, 6'd0, 6'd0, SYM_LAMBDA);    // closure holds the state itself
        queue_cmd(KIND_ADD_EDGE, 6'd0, 6'd63, SYM_LAMBDA);
        queue_cmd(KIND_ADD_EDGE, 6'd63, 6'd0, SYM_LAMBDA);  // lambda loop
        queue_cmd(KIND_ADD_EDGE, 6'd0, 6'd63, SYM_LAMBDA);  // same edge again
        queue_cmd(KIND_ADD_EDGE, 6'd63, 6'd42, 4'd15);
        queue_cmd(KIND_ADD_EDGE, 6'd0, 6'd21, 4'd5);
        queue_cmd(KIND_UNUSED, 6'd63, 6'd63, 4'd15);        // ignored, all ones
        queue_cmd(KIND_CLOSURE, 6'd0, 6'd63, 4'd15);
        queue_cmd(KIND_CLOSURE, 6'd63, 6'd0, SYM_LAMBDA);
        queue_cmd(KIND_MOVE, 6'd0, 6'd0, 4'd15);
        queue_cmd(KIND_MOVE, 6'd0, 6'd0, 4'd5);
        queue_cmd(KIND_MOVE, 6'd21, 6'd0, SYM_LAMBDA);      // lambda step from lone state
        queue_cmd(KIND_MOVE, 6'd0, 6'd0, SYM_LAMBDA);       // lambda step through the loop
        queue_cmd(KIND_ADD_EDGE, 6'd42, 6'd21, SYM_LAMBDA);
        queue_cmd(KIND_MOVE, 6'd63, 6'd0, 4'd15);           // no closure after the step
        queue_cmd(KIND_CLOSURE, 6'd42, 6'd0, SYM_LAMBDA);
        queue_cmd(KIND_ADD_EDGE, 6'd21, 6'd63, 4'd15);
        queue_cmd(KIND_MOVE, 6'd42, 6'd0, 4'd15);
        queue_cmd(KIND_CLOSURE, 6'd21, 6'd0, SYM_LAMBDA);
        queue_drain_pause();

        // Random: small state groups wired mostly by lambda, then queried.
        for (c = 0; c < 11; c++) begin
            for (j = 0; j < 6; j++)
                grp[j] = any_state();
            letter_a = SYM_W'($urandom_range(1, NUM_SYMBOLS - 1));
            letter_b = SYM_W'($urandom_range(1, NUM_SYMBOLS - 1));

            n = $urandom_range(4, 7);
            for (j = 0; j < n; j++) begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    pick_sym = letter_a;
                else if (r == 1)
                    pick_sym = letter_b;
                else
                    pick_sym = SYM_LAMBDA;
                queue_cmd(KIND_ADD_EDGE, grp[$urandom_range(0, 5)], grp[$urandom_range(0, 5)],
                          pick_sym);
            end

            n = $urandom_range(2, 4);
            for (j = 0; j < n; j++) begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    queue_cmd(KIND_CLOSURE, grp[$urandom_range(0, 5)], any_state(), any_symbol());
                else if (r == 1)
                    queue_cmd(KIND_MOVE, grp[$urandom_range(0, 5)], any_state(), letter_a);
                else if (r == 2)
                    queue_cmd(KIND_MOVE, grp[$urandom_range(0, 5)], any_state(), letter_b);
                else
                    queue_cmd(KIND_MOVE, grp[$urandom_range(0, 5)], any_state(), any_symbol());
            end

            // Noise: stray edges, ignored kinds, queries anywhere.
            n = $urandom_range(0, 2);
            for (j = 0; j < n; j++) begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    queue_cmd(KIND_ADD_EDGE, any_state(), any_state(), any_symbol());
                else if (r == 1)
                    queue_cmd(KIND_UNUSED, any_state(), any_state(), any_symbol());
                else if (r == 2)
                    queue_cmd(KIND_CLOSURE, any_state(), any_state(), any_symbol());
                else
                    queue_cmd(KIND_MOVE, any_state(), any_state(), any_symbol());
            end

            if (c == 5)
                queue_drain_pause();
        end

        // Fan one state out to every state on one letter, in random order,
        // so a move yields the full 64-member set.
        for (j = 0; j < NUM_STATES; j++)
            fan_order[j] = STATE_W'(j);
        for (j = NUM_STATES - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            swap_tmp     = fan_order[j];
            fan_order[j] = fan_order[k];
            fan_order[k] = swap_tmp;
        end
        fan_src  = any_state();
        pick_sym = SYM_W'($urandom_range(1, NUM_SYMBOLS - 1));
        for (j = 0; j < NUM_STATES; j++)
            queue_cmd(KIND_ADD_EDGE, fan_src, fan_order[j], pick_sym);
        queue_cmd(KIND_MOVE, fan_src, any_state(), pick_sym);
        queue_cmd(KIND_CLOSURE, fan_src, any_state(), any_symbol());
        queue_cmd(KIND_UNUSED, any_state(), any_state(), any_symbol());
        queue_cmd(KIND_MOVE, any_state(), any_state(), pick_sym);
        queue_cmd(KIND_MOVE, any_state(), any_state(), any_symbol());

        // Reset once; the block then runs its clearing pass with tready low.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is accepted and every result has come.
        while (cmd_backlog.size() != 0 || in_valid || pending_members.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_members.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
